FILE: rtl/smf_pkg.sv
// Shared types, constants and the length-code function for the sensor message framer.
// No dependencies; imported by smf_core, sensor_message_framer and the testbench tb.
`default_nettype none

package smf_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 6;
	localparam int unsigned CODE_W = 3;
	localparam int unsigned TYPE_W = 2;

	localparam logic [BYTE_W-1:0] CHECKSUM_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] PAD_BYTE      = 8'h00;
	localparam logic [TYPE_W-1:0] INFO_TYPE_RST = 2'd2;

	// One accepted input transaction
	typedef struct packed {
		logic [BYTE_W-1:0] command;
		logic [LEN_W-1:0]  payload_length;
		logic [BYTE_W-1:0] data_byte;
		logic              last_byte;
	} smf_item_t;

	// Smallest code c with 2**c >= len, for len in 1..32
	function automatic logic [CODE_W-1:0] length_code(input logic [LEN_W-1:0] len);
		logic [CODE_W-1:0] code;
		code = '0;
		for (int i = 0; i < 5; i++) begin
			if (len > (LEN_W'(1) << i))
				code = CODE_W'(i + 1);
		end
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/sensor_message_framer.sv
// Top level of the sensor message framer: input register, info type register and the
// sequencer smf_core. Depends on smf_pkg and smf_core.
//
// Frames a byte stream into length-coded messages with an XOR checksum. Each input
// transaction carries one payload byte; command and payload_length are read only on the
// first byte of a message. The block delivers one result byte per cycle, while the sink does not
// stall, through a result register: a mid-message byte within the frame yields its data byte, the
// first byte of a message a header and a data byte, and the last byte also any padding bytes and
// the checksum; input stalls while that burst drains.
// Write info_type_code only while no message is in progress.
`default_nettype none

module sensor_message_framer import smf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [TYPE_W-1:0] cfg_wdata,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire logic [BYTE_W-1:0] command,
	input  wire logic [LEN_W-1:0]  payload_length,
	input  wire logic [BYTE_W-1:0] data_byte,
	input  wire logic              last_byte,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   end_of_message
);

	logic [TYPE_W-1:0] info_type_q;
	logic              item_valid_s1;
	smf_item_t         item_s1;
	logic              item_take;
	logic              accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			info_type_q <= INFO_TYPE_RST;
		end else if (cfg_we) begin
			info_type_q <= cfg_wdata;
		end
	end

	assign item_stall = item_valid_s1 && !item_take;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (accept) begin
			item_valid_s1 <= 1'b1;
		end else if (item_take) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.command        <= command;
			item_s1.payload_length <= payload_length;
			item_s1.data_byte      <= data_byte;
			item_s1.last_byte      <= last_byte;
		end
	end

	smf_core #(
		.MAX_PAYLOAD(MAX_PAYLOAD)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.info_type_code(info_type_q),
		.item_valid_s1 (item_valid_s1),
		.item_s1       (item_s1),
		.item_take     (item_take),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_byte      (out_byte),
		.end_of_message(end_of_message)
	);

endmodule

`default_nettype wire

FILE: rtl/smf_core.sv
// Message sequencer and result register: turns one registered transaction into header,
// payload, padding and checksum bytes, one per cycle while the result is not stalled. Depends on smf_pkg.
`default_nettype none

module smf_core import smf_pkg::*; #(
	parameter int unsigned MAX_PAYLOAD = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [TYPE_W-1:0] info_type_code,
	input  wire logic              item_valid_s1,
	input  wire smf_item_t         item_s1,
	output logic                   item_take,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic [BYTE_W-1:0]      out_byte,
	output logic                   end_of_message
);

	localparam int unsigned FS_W = $clog2((1 << $clog2(MAX_PAYLOAD)) + 2);

	logic              in_msg_q, in_msg_n;
	logic [BYTE_W-1:0] cs_q, cs_n;
	logic [FS_W-1:0]   sent_q, sent_n;
	logic [FS_W-1:0]   fsize_q, fsize_n;
	logic              data_done_q, data_done_n;

	logic [LEN_W-1:0]  len_one, len_clamped;
	logic [CODE_W-1:0] code;
	logic [BYTE_W-1:0] header;
	logic [FS_W-1:0]   fsize_new;
	logic              room;
	logic              emit, emit_eom, done;
	logic [BYTE_W-1:0] emit_byte;
	logic              out_adv, step;

	// Header and frame size for a message opening with this transaction
	always_comb begin
		len_one     = (item_s1.payload_length == '0) ? LEN_W'(1) : item_s1.payload_length;
		len_clamped = (len_one > LEN_W'(MAX_PAYLOAD)) ? LEN_W'(MAX_PAYLOAD) : len_one;
		code        = length_code(len_clamped);
		header      = item_s1.command | {2'b00, code, 3'b000};
		fsize_new   = (FS_W'(1) << code)
			+ FS_W'(item_s1.command[BYTE_W-1 -: TYPE_W] == info_type_code);
	end

	assign room = (sent_q < fsize_q);

	always_comb begin
		emit        = 1'b0;
		emit_eom    = 1'b0;
		emit_byte   = PAD_BYTE;
		done        = 1'b0;
		in_msg_n    = in_msg_q;
		cs_n        = cs_q;
		sent_n      = sent_q;
		fsize_n     = fsize_q;
		data_done_n = data_done_q;
		if (!in_msg_q) begin
			emit      = 1'b1;
			emit_byte = header;
			in_msg_n  = 1'b1;
			fsize_n   = fsize_new;
			cs_n      = CHECKSUM_INIT ^ header;
			sent_n    = '0;
		end else if (!data_done_q && room) begin
			emit        = 1'b1;
			emit_byte   = item_s1.data_byte;
			cs_n        = cs_q ^ item_s1.data_byte;
			sent_n      = sent_q + FS_W'(1);
			data_done_n = 1'b1;
			done        = !item_s1.last_byte;
		end else if (!item_s1.last_byte) begin
			// beyond the frame size: drop
			done = 1'b1;
		end else if (room) begin
			emit      = 1'b1;
			emit_byte = PAD_BYTE;
			sent_n    = sent_q + FS_W'(1);
		end else begin
			emit      = 1'b1;
			emit_eom  = 1'b1;
			emit_byte = cs_q;
			done      = 1'b1;
			in_msg_n  = 1'b0;
			cs_n      = CHECKSUM_INIT;
			sent_n    = '0;
			fsize_n   = '0;
		end
		if (done)
			data_done_n = 1'b0;
	end

	assign out_adv   = !result_valid || !result_stall;
	assign step      = item_valid_s1 && (!emit || out_adv);
	assign item_take = step && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q    <= 1'b0;
			cs_q        <= CHECKSUM_INIT;
			sent_q      <= '0;
			fsize_q     <= '0;
			data_done_q <= 1'b0;
		end else if (step) begin
			in_msg_q    <= in_msg_n;
			cs_q        <= cs_n;
			sent_q      <= sent_n;
			fsize_q     <= fsize_n;
			data_done_q <= data_done_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (out_adv) begin
			result_valid <= step && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			out_byte       <= emit_byte;
			end_of_message <= emit_eom;
		end
	end

	a_sent_bound: assert property (@(posedge clk) disable iff (!arst_n)
		in_msg_q |-> (sent_q <= fsize_q))
		else $error("bytes sent exceed frame size");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		!in_msg_q |-> (sent_q == '0 && cs_q == CHECKSUM_INIT && !data_done_q))
		else $error("message state not cleared between messages");

	a_take_valid: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_valid_s1)
		else $error("transaction taken from an empty input register");

	a_eom_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit_eom) |=> (!in_msg_q && result_valid && end_of_message))
		else $error("checksum did not close the message");

endmodule

`default_nettype wire

FILE: dv/tb.sv
// Self-checking testbench for sensor_message_framer: random bursty stimulus, stalling sink,
// and a scoreboard fed by an in-bench framing predictor.
// Depends on smf_pkg and the RTL of sensor_message_framer.

module tb;
	import smf_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned MSG_MAX_LEN   = 32;
	localparam int unsigned SETTLE_CYCLES = 12;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam int unsigned PHASE_ITEMS   = 30;
	localparam int unsigned MAX_REPORTS   = 30;

	// One transmitted byte as the sink should see it
	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              eom;
	} frame_byte_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [TYPE_W-1:0] cfg_wdata = '0;
	logic              item_valid = 1'b0;
	logic              item_stall;
	logic [BYTE_W-1:0] command = '0;
	logic [LEN_W-1:0]  payload_length = '0;
	logic [BYTE_W-1:0] data_byte = '0;
	logic              last_byte = 1'b0;
	logic              result_valid;
	logic              result_stall = 1'b0;
	logic [BYTE_W-1:0] out_byte;
	logic              end_of_message;

	smf_item_t    pending_items[$];
	frame_byte_t  expected_bytes[$];
	smf_item_t    drv_item = '0;
	int unsigned  gap_left = 0;
	int unsigned  burst_left = 0;

	// Predictor state
	logic [TYPE_W-1:0] info_sel = INFO_TYPE_RST;
	logic              msg_open = 1'b0;
	logic [BYTE_W-1:0] csum = CHECKSUM_INIT;
	int unsigned       bytes_out = 0;
	int unsigned       frame_len = 0;

	int unsigned err_count = 0;
	int unsigned items_accepted = 0;
	int unsigned msgs_closed = 0;
	int unsigned bytes_checked = 0;
	int unsigned pads_predicted = 0;
	int unsigned dropped_bytes = 0;
	int unsigned cycle_count = 0;
	int unsigned rx_cycle = 0;

	sensor_message_framer u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.item_valid     (item_valid),
		.item_stall     (item_stall),
		.command        (command),
		.payload_length (payload_length),
		.data_byte      (data_byte),
		.last_byte      (last_byte),
		.result_valid   (result_valid),
		.result_stall   (result_stall),
		.out_byte       (out_byte),
		.end_of_message (end_of_message)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string msg);
		err_count++;
		if (err_count <= MAX_REPORTS)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	// Work out the bytes one accepted transaction puts on the output side
	task automatic frame_predict(input smf_item_t it);
		int unsigned clen;
		int unsigned code;
		logic [BYTE_W-1:0] hdr;
		if (!msg_open) begin
			clen = it.payload_length;
			if (clen == 0)
				clen = 1;
			if (clen > MSG_MAX_LEN)
				clen = MSG_MAX_LEN;
			code = 0;
			while ((1 << code) < clen)
				code++;
			hdr = it.command | BYTE_W'(code << 3);
			frame_len = (1 << code) + ((it.command[7:6] == info_sel) ? 1 : 0);
			csum = CHECKSUM_INIT ^ hdr;
			bytes_out = 0;
			msg_open = 1'b1;
			expected_bytes.push_back('{hdr, 1'b0});
		end
		if (bytes_out < frame_len) begin
			csum ^= it.data_byte;
			bytes_out++;
			expected_bytes.push_back('{it.data_byte, 1'b0});
		end else begin
			dropped_bytes++;
		end
		if (it.last_byte) begin
			while (bytes_out < frame_len) begin
				bytes_out++;
				pads_predicted++;
				expected_bytes.push_back('{PAD_BYTE, 1'b0});
			end
			expected_bytes.push_back('{csum, 1'b1});
			msg_open = 1'b0;
			csum = CHECKSUM_INIT;
			bytes_out = 0;
			frame_len = 0;
			msgs_closed++;
		end
	endtask

	// Queue one message; data < 0 picks random payload bytes
	task automatic add_message(input logic [BYTE_W-1:0] cmd, input logic [LEN_W-1:0] len,
			input int unsigned nbytes, input int data);
		smf_item_t it;
		for (int i = 0; i < nbytes; i++) begin
			it.command        = (i == 0) ? cmd : BYTE_W'($urandom_range(0, 255));
			it.payload_length = (i == 0) ? len : LEN_W'($urandom_range(0, 63));
			it.data_byte      = (data < 0) ? BYTE_W'($urandom_range(0, 255)) : BYTE_W'(data);
			it.last_byte      = (i == nbytes - 1);
			pending_items.push_back(it);
		end
	endtask

	task automatic load_random(input int unsigned n_items);
		int unsigned queued;
		int unsigned sel;
		int unsigned clen;
		int unsigned nbytes;
		logic [BYTE_W-1:0] cmd;
		logic [LEN_W-1:0] len;
		queued = 0;
		while (queued < n_items) begin
			cmd = BYTE_W'($urandom_range(0, 255));
			if ($urandom_range(0, 9) < 4)
				cmd[7:6] = info_sel;
			sel = $urandom_range(0, 9);
			if (sel < 7)
				len = LEN_W'($urandom_range(0, 8));
			else if (sel < 9)
				len = LEN_W'($urandom_range(9, 32));
			else
				len = LEN_W'($urandom_range(33, 63));
			clen = (len == 0) ? 1 : ((len > MSG_MAX_LEN) ? MSG_MAX_LEN : len);
			// Mostly well-formed, the rest short or running past the frame
			sel = $urandom_range(0, 19);
			if (sel < 14)
				nbytes = clen;
			else if (sel < 17)
				nbytes = $urandom_range(1, clen);
			else
				nbytes = clen + $urandom_range(1, 3);
			add_message(cmd, len, nbytes, -1);
			queued += nbytes;
		end
	endtask

	task automatic load_directed();
		add_message(8'h00, 6'd0, 1, 8'hFF);     // zero length, single byte
		add_message(8'hFF, 6'd63, 1, 8'h00);    // saturated length, code bits preset
		add_message(8'h80, 6'd32, 1, -1);       // info message at full size, padded after one byte
		add_message(8'h80, 6'd2, 4, -1);        // info type: extra byte, last one excess
		add_message(8'h41, 6'd3, 6, -1);        // excess bytes dropped before the last
		add_message(8'hC7, 6'd5, 2, -1);        // short message padded
		add_message(8'h38, 6'd1, 1, -1);
		add_message(8'h15, 6'd9, 9, -1);        // length 9 sent in full, padded to the frame size
	endtask

	task automatic wait_drained();
		while (pending_items.size() != 0 || item_valid || expected_bytes.size() != 0)
			@(posedge clk);
		// excess bytes give no result, so let the pipe settle before touching config
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_info_type(input logic [TYPE_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		info_sel = v;
	endtask

	// Sender: bursts of random length separated by random gaps
	always @(posedge clk) begin : drive_proc
		logic nv;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			nv = item_valid;
			if (item_valid && !item_stall) begin
				frame_predict(drv_item);
				items_accepted++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_items.size() != 0) begin
					drv_item = pending_items.pop_front();
					nv = 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 16);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left--;
					end
				end
			end
			item_valid     <= nv;
			command        <= drv_item.command;
			payload_length <= drv_item.payload_length;
			data_byte      <= drv_item.data_byte;
			last_byte      <= drv_item.last_byte;
		end
	end

	// Sink: stall pattern cycles through free, light, heavy and periodic
	always @(posedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 128) % 4)
			0: result_stall <= 1'b0;
			1: result_stall <= ($urandom_range(0, 3) == 0);
			2: result_stall <= ($urandom_range(0, 3) != 0);
			default: result_stall <= (rx_cycle % 3 == 0);
		endcase
	end

	always @(posedge clk) begin : check_proc
		frame_byte_t exp_b;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_bytes.size() == 0) begin
				report_mismatch($sformatf("unexpected byte %02h eom %0b", out_byte,
					end_of_message));
			end else begin
				exp_b = expected_bytes.pop_front();
				bytes_checked++;
				if (out_byte !== exp_b.value)
					report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte,
						exp_b.value));
				if (end_of_message !== exp_b.eom)
					report_mismatch($sformatf("end_of_message %0b, expected %0b",
						end_of_message, exp_b.eom));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d bytes outstanding", cycle_count,
				expected_bytes.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stim_proc
		logic [TYPE_W-1:0] settings[4];
		settings = '{2'd0, 2'd3, 2'd1, 2'd2};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		load_directed();
		wait_drained();
		foreach (settings[i]) begin
			set_info_type(settings[i]);
			load_random(PHASE_ITEMS);
			wait_drained();
		end
		if (expected_bytes.size() != 0)
			report_mismatch($sformatf("%0d expected bytes never arrived",
				expected_bytes.size()));
		$display("Covered %0d input transactions in %0d messages, info type 2/0/3/1/2.",
			items_accepted, msgs_closed);
		$display("Checked %0d output bytes: %0d pad bytes, %0d excess bytes dropped.",
			bytes_checked, pads_predicted, dropped_bytes);
		if (err_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
